/* src/ecm_pkg.sv */
// shared constants and types for the edge coverage map unit
// no dependencies; every other file refers to it by scoped names

package ecm_pkg;

   // map geometry
   localparam int MAP_ENTRIES = 65536;
   localparam int IDX_W       = $clog2(MAP_ENTRIES);

   // field widths
   localparam int ADDR_W = 48;
   localparam int CNT_W  = 8;
   localparam int REQ_W  = 2;
   localparam int HIT_W  = 16;
   localparam int RIDX_W = 16;

   // index masks: map size, and the 16-bit limit on the previous location
   localparam logic [IDX_W-1:0] IDX_MASK  = IDX_W'(MAP_ENTRIES - 1);
   localparam logic [IDX_W-1:0] PREV_MASK = IDX_W'(32'h0000_FFFF);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAP_ENTRIES - 1);

   // request codes
   localparam logic [REQ_W-1:0] REQ_BLOCK = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_SEL_BIT = 3;
   localparam logic CSR_SEL_BASE = 1'b0;
   localparam logic CSR_SEL_END  = 1'b1;

   // item leaving the index stage toward the counter update
   typedef struct packed {
      logic              valid;
      logic [REQ_W-1:0]  req;
      logic              counted;
      logic [IDX_W-1:0]  idx;
      logic [RIDX_W-1:0] ridx;
   } lookup_type;

   // index stage status seen by the control logic
   typedef struct packed {
      logic valid;
      logic hold;
   } stage_status_type;

   // counter memory write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [CNT_W-1:0] data;
   } wr_port_type;

endpackage

/* src/ecm_counter_ram.sv */
// counter map storage: one write port, one registered read port
// depends on ecm_pkg for map size and counter width

module ecm_counter_ram (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ecm_pkg::IDX_W-1:0] rd_addr,
   output logic [ecm_pkg::CNT_W-1:0] rd_data,
   input  ecm_pkg::wr_port_type      wr
);

   logic [ecm_pkg::CNT_W-1:0] mem [ecm_pkg::MAP_ENTRIES];
   logic [ecm_pkg::CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read returns the value before a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ecm_index_stage.sv */
// input register, module window check, edge index and previous location
// depends on ecm_pkg for widths, request codes and the lookup struct

module ecm_index_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [ecm_pkg::REQ_W-1:0]   req_type,
   input  logic [ecm_pkg::ADDR_W-1:0]  req_block_addr,
   input  logic [ecm_pkg::RIDX_W-1:0]  req_read_index,
   input  logic [ecm_pkg::ADDR_W-1:0]  module_base,
   input  logic [ecm_pkg::ADDR_W-1:0]  module_end,
   input  logic                        adv,
   input  logic                        sweep_done,
   output ecm_pkg::stage_status_type   status,
   output ecm_pkg::lookup_type         lookup
);

   logic                        b_valid_ff;
   logic                        b_done_ff;
   logic [ecm_pkg::REQ_W-1:0]   b_req_ff;
   logic [ecm_pkg::ADDR_W-1:0]  b_addr_ff;
   logic [ecm_pkg::RIDX_W-1:0]  b_ridx_ff;
   logic [ecm_pkg::IDX_W-1:0]   prev_ff;
   logic [ecm_pkg::IDX_W-1:0]   prev_in;

   logic [ecm_pkg::ADDR_W-1:0]  offset;
   logic                        in_window;
   logic                        counted;
   logic [ecm_pkg::IDX_W-1:0]   edge_idx;
   logic [ecm_pkg::IDX_W-1:0]   read_idx;

   assign in_window = (b_addr_ff >= module_base) && (b_addr_ff <= module_end);
   assign offset    = b_addr_ff - module_base;
   assign counted   = b_valid_ff && (b_req_ff == ecm_pkg::REQ_BLOCK) && in_window;
   assign edge_idx  = (offset[ecm_pkg::IDX_W-1:0] ^ prev_ff) & ecm_pkg::IDX_MASK;
   assign read_idx  = ecm_pkg::IDX_W'(b_ridx_ff) & ecm_pkg::IDX_MASK;
   assign prev_in   = offset[ecm_pkg::IDX_W:1] & ecm_pkg::IDX_MASK & ecm_pkg::PREV_MASK;

   assign lookup.valid   = b_valid_ff;
   assign lookup.req     = b_req_ff;
   assign lookup.counted = counted;
   assign lookup.idx     = (b_req_ff == ecm_pkg::REQ_READ) ? read_idx : edge_idx;
   assign lookup.ridx    = b_ridx_ff;

   // a clear waits here until the map sweep has finished
   assign status.valid = b_valid_ff;
   assign status.hold  = b_valid_ff && (b_req_ff == ecm_pkg::REQ_CLEAR) && !b_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_done_ff  <= 1'b0;
         prev_ff    <= '0;
      end else begin
         b_valid_ff <= accept || (b_valid_ff && !adv);
         if (adv && counted) begin
            prev_ff <= prev_in;
         end
         if (accept) begin
            b_done_ff <= 1'b0;
         end else if (sweep_done) begin
            b_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_req_ff  <= req_type;
         b_addr_ff <= req_block_addr;
         b_ridx_ff <= req_read_index;
      end
   end

endmodule

/* src/ecm_update_stage.sv */
// counter increment with write forwarding, and the result register
// depends on ecm_pkg for the lookup struct, the write port and request codes

module ecm_update_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        load,
   input  logic                        run,
   input  ecm_pkg::lookup_type         lookup,
   input  logic [ecm_pkg::CNT_W-1:0]   rd_data,
   output ecm_pkg::wr_port_type        wr,
   output logic                        busy,
   output logic                        rsp_valid,
   output logic [ecm_pkg::HIT_W-1:0]   rsp_hit_index,
   output logic                        rsp_counted,
   output logic [ecm_pkg::CNT_W-1:0]   rsp_entry_value
);

   ecm_pkg::lookup_type        c_ff;
   ecm_pkg::lookup_type        c_in;
   logic                       fwd_valid_ff;
   logic [ecm_pkg::IDX_W-1:0]  fwd_idx_ff;
   logic [ecm_pkg::CNT_W-1:0]  fwd_val_ff;

   logic                       out_valid_ff;
   logic [ecm_pkg::HIT_W-1:0]  out_hit_ff;
   logic                       out_counted_ff;
   logic [ecm_pkg::CNT_W-1:0]  out_value_ff;

   logic [ecm_pkg::CNT_W-1:0]  old_value;
   logic [ecm_pkg::CNT_W-1:0]  new_value;
   logic [ecm_pkg::HIT_W-1:0]  hit_in;
   logic                       counted_in;
   logic [ecm_pkg::CNT_W-1:0]  value_in;

   // the write of the item just ahead lands on the same edge as this read
   assign old_value = (fwd_valid_ff && (fwd_idx_ff == c_ff.idx)) ? fwd_val_ff : rd_data;
   assign new_value = old_value + ecm_pkg::CNT_W'(1);

   assign wr.en   = en && c_ff.valid && c_ff.counted;
   assign wr.addr = c_ff.idx;
   assign wr.data = new_value;

   assign busy = c_ff.valid;

   always_comb begin
      c_in       = lookup;
      c_in.valid = load && lookup.valid;
      hit_in     = '0;
      counted_in = 1'b0;
      value_in   = '0;
      case (c_ff.req)
         ecm_pkg::REQ_BLOCK: begin
            if (c_ff.counted) begin
               hit_in     = ecm_pkg::HIT_W'(c_ff.idx);
               counted_in = 1'b1;
               value_in   = new_value;
            end
         end
         ecm_pkg::REQ_READ: begin
            hit_in   = c_ff.ridx;
            value_in = old_value;
         end
         default: begin
            hit_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!run) begin
            fwd_valid_ff <= 1'b0;
         end else if (en) begin
            fwd_valid_ff <= wr.en;
         end
         if (en) begin
            c_ff.valid   <= c_in.valid;
            out_valid_ff <= c_ff.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff.req     <= c_in.req;
         c_ff.counted <= c_in.counted;
         c_ff.idx     <= c_in.idx;
         c_ff.ridx    <= c_in.ridx;
         fwd_idx_ff   <= c_ff.idx;
         fwd_val_ff   <= new_value;
         if (c_ff.valid) begin
            out_hit_ff     <= hit_in;
            out_counted_ff <= counted_in;
            out_value_ff   <= value_in;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_hit_index   = out_hit_ff;
   assign rsp_counted     = out_counted_ff;
   assign rsp_entry_value = out_value_ff;

endmodule

/* src/edge_coverage_map_unit.sv */
// a result passes the input, update and result registers before it shows on rsp_valid
// throughput: one block event or read per cycle unless stalled, set by the counter read-modify-write
// a clear drains the pipe, then sweeps the map one entry a cycle, through every entry
// reset: synchronous; afterwards the map is swept to zero while req_stall stays high;
// register writes are taken throughout
// depends on ecm_pkg, ecm_counter_ram, ecm_index_stage and ecm_update_stage

module edge_coverage_map_unit (
   input  logic                            clock,
   input  logic                            reset,

   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ecm_pkg::REQ_W-1:0]       req_type,
   input  logic [ecm_pkg::ADDR_W-1:0]      req_block_addr,
   input  logic [ecm_pkg::RIDX_W-1:0]      req_read_index,

   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ecm_pkg::HIT_W-1:0]       rsp_hit_index,
   output logic                            rsp_counted,
   output logic [ecm_pkg::CNT_W-1:0]       rsp_entry_value,

   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ecm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ecm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ecm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_RUN,
      ST_CLEAR
   } state_type;

   state_type                     state_ff;
   logic [ecm_pkg::IDX_W-1:0]     sweep_idx_ff;

   logic [ecm_pkg::ADDR_W-1:0]    base_ff;
   logic [ecm_pkg::ADDR_W-1:0]    end_ff;

   ecm_pkg::stage_status_type     idx_status;
   ecm_pkg::lookup_type           lookup;
   ecm_pkg::wr_port_type          upd_wr;
   ecm_pkg::wr_port_type          ram_wr;
   logic [ecm_pkg::CNT_W-1:0]     rd_data;

   logic                          en;
   logic                          adv;
   logic                          accept;
   logic                          run;
   logic                          sweep_last;
   logic                          sweep_done;
   logic                          upd_busy;
   logic                          csr_write;

   // ---------------------------------------------------------------
   // register port: 48-bit registers at byte offsets 0 and 8
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         end_ff  <= '0;
      end else if (csr_write) begin
         if (csr_paddr[ecm_pkg::CSR_SEL_BIT] == ecm_pkg::CSR_SEL_END) begin
            end_ff <= csr_pwdata[ecm_pkg::ADDR_W-1:0];
         end else begin
            base_ff <= csr_pwdata[ecm_pkg::ADDR_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[ecm_pkg::CSR_SEL_BIT] == ecm_pkg::CSR_SEL_BASE) begin
         csr_prdata = ecm_pkg::CSR_DATA_W'(base_ff);
      end else begin
         csr_prdata = ecm_pkg::CSR_DATA_W'(end_ff);
      end
   end

   // ---------------------------------------------------------------
   // pipe control
   // ---------------------------------------------------------------
   // the whole pipe freezes while a finished result is stalled
   assign en  = !(rsp_valid && rsp_stall);
   // index stage moves on unless it holds a clear waiting for its sweep
   assign adv = en && !idx_status.hold;
   assign run = (state_ff == ST_RUN);

   // no transfers while the map is swept after reset
   assign req_stall = (state_ff == ST_INIT) || (idx_status.valid && !adv);
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // map sweep sequencer: reset fill and clear requests
   // ---------------------------------------------------------------
   assign sweep_last = (sweep_idx_ff == ecm_pkg::LAST_IDX);
   assign sweep_done = (state_ff == ST_CLEAR) && sweep_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_idx_ff <= '0;
      end else begin
         case (state_ff)
            ST_INIT: begin
               sweep_idx_ff <= sweep_idx_ff + ecm_pkg::IDX_W'(1);
               if (sweep_last) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               // start only once the update stage has written back
               sweep_idx_ff <= '0;
               if (idx_status.hold && !upd_busy) begin
                  state_ff <= ST_CLEAR;
               end
            end
            ST_CLEAR: begin
               sweep_idx_ff <= sweep_idx_ff + ecm_pkg::IDX_W'(1);
               if (sweep_last) begin
                  state_ff <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_INIT;
            end
         endcase
      end
   end

   // sweep owns the write port; the update stage is empty meanwhile
   always_comb begin
      if (run) begin
         ram_wr = upd_wr;
      end else begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = sweep_idx_ff;
         ram_wr.data = '0;
      end
   end

   // ---------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------
   ecm_index_stage u_index (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_type),
      .req_block_addr (req_block_addr),
      .req_read_index (req_read_index),
      .module_base    (base_ff),
      .module_end     (end_ff),
      .adv            (adv),
      .sweep_done     (sweep_done),
      .status         (idx_status),
      .lookup         (lookup)
   );

   // the counter read is issued on the edge the item enters the update stage
   ecm_counter_ram u_ram (
      .clock   (clock),
      .rd_en   (en),
      .rd_addr (lookup.idx),
      .rd_data (rd_data),
      .wr      (ram_wr)
   );

   ecm_update_stage u_update (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .load            (adv),
      .run             (run),
      .lookup          (lookup),
      .rd_data         (rd_data),
      .wr              (upd_wr),
      .busy            (upd_busy),
      .rsp_valid       (rsp_valid),
      .rsp_hit_index   (rsp_hit_index),
      .rsp_counted     (rsp_counted),
      .rsp_entry_value (rsp_entry_value)
   );

endmodule

/* src/ecm_checker.sv */
// port-level checks for the edge coverage map unit, bound to the top level
// depends on ecm_pkg for field widths

module ecm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ecm_pkg::HIT_W-1:0]     rsp_hit_index,
   input logic                          rsp_counted,
   input logic [ecm_pkg::CNT_W-1:0]     rsp_entry_value
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_index)
         && $stable(rsp_counted) && $stable(rsp_entry_value))
      else $error("stalled result changed");

   // reset flushes any pending result
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the map sweep after reset blocks requests
   a_init_stall: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken during reset sweep");

endmodule

bind edge_coverage_map_unit ecm_checker u_ecm_checker (.*);
